// ===== hdl/swts_pkg.sv =====
// Package: shared constants and types for the software timer scheduler.
`default_nettype none

package swts_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [1:0] FUNC_REGISTER   = 2'd0;
  localparam logic [1:0] FUNC_UNREGISTER = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_TOP,
    ST_SET_BASE,
    ST_SCAN_FIRE,
    ST_FIRE,
    ST_SCAN_STAT,
    ST_STAT
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/software_timer_scheduler_core.sv =====
// Software timer scheduler core: slot table, scan sequencer and result register.
// Register and unregister: the slot is updated on accept, then a status scan yields the status word.
// Timeout: top scan, base set, fire scan and fire step while a timer is due, then status scan;
// all use the one shared 32-bit subtract/compare unit that visits one slot per cycle.
// One word in flight at a time; a new word is taken while the last result waits.
// Reset (async, active low) disarms every slot and clears the sequencer and output valid.
`default_nettype none

module software_timer_scheduler_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [31:0] interval_i,
  input  wire logic        periodic_i,
  input  wire logic [31:0] now_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             fired_o,
  output logic [3:0]       fired_slot_o,
  output logic             timeout_armed_o,
  output logic [30:0]      timeout_delay_o,
  output logic             last_o
);

  localparam int N = swts_pkg::NUM_TIMERS;
  localparam int W = swts_pkg::IDX_W;

  swts_pkg::state_e state_q, state_d;

  logic [31:0]  dl_q     [N];
  logic [31:0]  reload_q [N];
  logic [N-1:0] per_q;
  logic [N-1:0] armed_q;
  logic [N-1:0] done_q;

  logic [31:0]  now_q;
  logic [31:0]  base_q;
  logic [W-1:0] cnt_q;
  logic [W-1:0] best_q;
  logic         found_q;
  logic [31:0]  key_q;
  logic [31:0]  bdl_q;

  logic         out_valid_q;
  logic         fired_q;
  logic [3:0]   fslot_q;
  logic         tarmed_q;
  logic [30:0]  tdelay_q;
  logic         last_q;

  logic         accept;
  logic         emit_ok;
  logic         cnt_last;
  logic         scan_en;
  logic         signed_mode;
  logic         scan_clr;
  logic         fire_emit;
  logic         stat_emit;
  logic         in_scan_d;
  logic         in_scan;

  logic [W-1:0] slot_idx;
  logic         slot_ok;
  logic [W-1:0] sel_idx;
  logic [31:0]  ref_val;
  logic [31:0]  dl_rd;
  logic [31:0]  diff;
  logic         diff_pos;
  logic         cand;
  logic         better;

  assign accept   = (state_q == swts_pkg::ST_IDLE) && in_valid_i;
  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign cnt_last = (cnt_q == W'(N - 1));
  assign slot_idx = W'(slot_i);
  assign slot_ok  = (32'(slot_i) < 32'(N));

  // shared subtract/compare unit
  assign sel_idx  = (state_q == swts_pkg::ST_FIRE) ? best_q : cnt_q;
  assign ref_val  = (state_q == swts_pkg::ST_SCAN_FIRE) ? base_q : now_q;
  assign dl_rd    = dl_q[sel_idx];
  assign diff     = dl_rd - ref_val;
  assign diff_pos = !diff[31] && (diff != 32'd0);
  assign cand     = armed_q[cnt_q] &&
                    ((state_q != swts_pkg::ST_SCAN_FIRE) || !done_q[cnt_q]);
  assign better   = !found_q ||
                    (signed_mode ? ($signed(diff) < $signed(key_q)) : (diff < key_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      swts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (func_i == swts_pkg::FUNC_TIMEOUT) ? swts_pkg::ST_SCAN_TOP
                                                        : swts_pkg::ST_SCAN_STAT;
        end
      end
      swts_pkg::ST_SCAN_TOP: begin
        if (cnt_last) state_d = swts_pkg::ST_SET_BASE;
      end
      swts_pkg::ST_SET_BASE: state_d = swts_pkg::ST_SCAN_FIRE;
      swts_pkg::ST_SCAN_FIRE: begin
        if (cnt_last) state_d = swts_pkg::ST_FIRE;
      end
      swts_pkg::ST_FIRE: begin
        if (!found_q || diff_pos) state_d = swts_pkg::ST_SCAN_STAT;
        else if (emit_ok) state_d = swts_pkg::ST_SCAN_FIRE;
      end
      swts_pkg::ST_SCAN_STAT: begin
        if (cnt_last) state_d = swts_pkg::ST_STAT;
      end
      swts_pkg::ST_STAT: begin
        if (emit_ok) state_d = swts_pkg::ST_IDLE;
      end
      default: state_d = swts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    scan_en     = 1'b0;
    signed_mode = 1'b0;
    fire_emit   = 1'b0;
    stat_emit   = 1'b0;
    in_scan     = 1'b0;
    in_scan_d   = 1'b0;
    case (state_q)
      swts_pkg::ST_SCAN_TOP: begin
        scan_en = 1'b1; signed_mode = 1'b1; in_scan = 1'b1;
      end
      swts_pkg::ST_SCAN_FIRE: begin
        scan_en = 1'b1; in_scan = 1'b1;
      end
      swts_pkg::ST_SCAN_STAT: begin
        scan_en = 1'b1; signed_mode = 1'b1; in_scan = 1'b1;
      end
      swts_pkg::ST_FIRE: fire_emit = found_q && !diff_pos && emit_ok;
      swts_pkg::ST_STAT: stat_emit = emit_ok;
      default: ;
    endcase
    case (state_d)
      swts_pkg::ST_SCAN_TOP, swts_pkg::ST_SCAN_FIRE, swts_pkg::ST_SCAN_STAT:
        in_scan_d = 1'b1;
      default: in_scan_d = 1'b0;
    endcase
  end

  assign scan_clr = in_scan_d && !in_scan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swts_pkg::ST_IDLE;
      armed_q     <= '0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && slot_ok) begin
        if (func_i == swts_pkg::FUNC_REGISTER) armed_q[slot_idx] <= 1'b1;
        else if (func_i == swts_pkg::FUNC_UNREGISTER) armed_q[slot_idx] <= 1'b0;
      end
      if (fire_emit && !per_q[best_q]) armed_q[best_q] <= 1'b0;
      if (scan_clr) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else if (scan_en) begin
        cnt_q <= cnt_q + W'(1);
        if (cand && better) found_q <= 1'b1;
      end
      if (fire_emit || stat_emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) now_q <= now_i;
    if (accept && slot_ok && (func_i == swts_pkg::FUNC_REGISTER)) begin
      dl_q[slot_idx]     <= now_i + interval_i;
      reload_q[slot_idx] <= interval_i;
      per_q[slot_idx]    <= periodic_i;
    end
    if (fire_emit) begin
      done_q[best_q] <= 1'b1;
      if (per_q[best_q]) dl_q[best_q] <= now_q + reload_q[best_q];
    end
    if (state_q == swts_pkg::ST_SET_BASE) begin
      done_q <= '0;
      base_q <= (found_q && key_q[31] && (key_q[30:0] != 31'd0)) ? bdl_q : now_q;
    end
    if (scan_en && cand && better) begin
      best_q <= cnt_q;
      key_q  <= diff;
      bdl_q  <= dl_rd;
    end
    if (fire_emit) begin
      fired_q  <= 1'b1;
      fslot_q  <= 4'(best_q);
      tarmed_q <= 1'b0;
      tdelay_q <= '0;
      last_q   <= 1'b0;
    end else if (stat_emit) begin
      fired_q  <= 1'b0;
      fslot_q  <= '0;
      tarmed_q <= found_q;
      tdelay_q <= (found_q && !key_q[31]) ? key_q[30:0] : 31'd0;
      last_q   <= 1'b1;
    end
  end

  assign in_stall_o      = (state_q != swts_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign fired_o         = fired_q;
  assign fired_slot_o    = fslot_q;
  assign timeout_armed_o = tarmed_q;
  assign timeout_delay_o = tdelay_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire
